// ===== rtl/core/ifmt_pkg.sv =====
// ---------------------------------------------------------------------------
// ifmt_pkg: shared definitions of the integer field formatter
// Value width, digit buffer sizing and the request/response bundles of the
// shared divide unit.
// ---------------------------------------------------------------------------
package ifmt_pkg;

	// Width of the converted value (16 to 64).
	localparam int VALUE_BITS = 64;
	// Largest number of characters emitted for one field (16 to 64).
	localparam int MAX_CHARS  = 64;

	// Radix field width; remainders and digits fit in the same width.
	localparam int BASE_W     = 6;
	// Quotient bits retired per divider cycle.
	localparam int DIV_STEP   = 8;
	localparam int DIV_CYC    = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
	localparam int DIV_W      = DIV_CYC * DIV_STEP;
	localparam int DIV_CNT_W  = $clog2(DIV_CYC + 1);

	// Digit buffer: base 2 gives at most VALUE_BITS digits.
	localparam int DIG_DEPTH  = VALUE_BITS;
	localparam int DIG_AW     = $clog2(DIG_DEPTH);

	// Character positions: at most 64 pad/precision plus sign and prefix.
	localparam int POS_W      = 7;

	typedef struct packed {
		logic                  start;
		logic [VALUE_BITS-1:0] dividend;
		logic [BASE_W-1:0]     divisor;
	} div_req_t;

	typedef struct packed {
		logic                  busy;
		logic                  done;
		logic [VALUE_BITS-1:0] quotient;
		logic [BASE_W-1:0]     remainder;
	} div_rsp_t;

endpackage

// ===== rtl/core/ifmt_ram.sv =====
// ---------------------------------------------------------------------------
// ifmt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module ifmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/core/ifmt_div.sv =====
// ---------------------------------------------------------------------------
// ifmt_div: iterative radix divider
// Divides the value by a small base, DIV_STEP quotient bits per cycle,
// and returns quotient and remainder with a one-cycle done pulse.
// ---------------------------------------------------------------------------
module ifmt_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ifmt_pkg::div_req_t req,
	output ifmt_pkg::div_rsp_t rsp
);

	logic [ifmt_pkg::DIV_W-1:0]     quo_q;
	logic [ifmt_pkg::BASE_W-1:0]    rem_q;
	logic [ifmt_pkg::BASE_W-1:0]    divisor_q;
	logic [ifmt_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [ifmt_pkg::DIV_W-1:0]     quo_nxt;
	logic [ifmt_pkg::BASE_W:0]      part;
	logic [ifmt_pkg::BASE_W-1:0]    rem_nxt;

	// Restoring division, one shift/compare/subtract per quotient bit.
	always_comb begin
		quo_nxt = quo_q;
		part    = {1'b0, rem_q};
		for (int k = 0; k < ifmt_pkg::DIV_STEP; k++) begin
			part    = {part[ifmt_pkg::BASE_W-1:0], quo_nxt[ifmt_pkg::DIV_W-1]};
			quo_nxt = {quo_nxt[ifmt_pkg::DIV_W-2:0], 1'b0};
			if (part >= {1'b0, divisor_q}) begin
				part       = part - {1'b0, divisor_q};
				quo_nxt[0] = 1'b1;
			end
		end
		rem_nxt = part[ifmt_pkg::BASE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= ifmt_pkg::DIV_CNT_W'(ifmt_pkg::DIV_CYC);
			end else if (busy_q) begin
				cnt_q <= cnt_q - ifmt_pkg::DIV_CNT_W'(1);
				if (cnt_q == ifmt_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers carry no reset.
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			quo_q     <= ifmt_pkg::DIV_W'(req.dividend);
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= quo_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q[ifmt_pkg::VALUE_BITS-1:0];
	assign rsp.remainder = rem_q;

endmodule

// ===== rtl/core/integer_field_formatter.sv =====
// ---------------------------------------------------------------------------
// integer_field_formatter: printf-style integer to ASCII field formatter
// Converts one value per transaction and streams out its characters.
// ---------------------------------------------------------------------------
// One input transaction carries a value, a base (2 to 36), a field width, a
// minimum digit count and the format flags; the block answers with one
// output transaction per character, in the order leading spaces, sign,
// prefix, zero padding, precision zeros, digits, trailing spaces, with
// tlast on the final character. A bad base gives a single transaction with
// character 0 and the bad_base flag; a field longer than MAX_CHARS is cut
// there and its final character carries the truncated flag. The block
// works on one item at a time and takes a new one once the last character
// of the previous one sits in the output register. One shared divider
// produces the digits least significant first into a small digit RAM,
// one divider pass per digit and none for a zero value. Each character
// takes a registered read of the digit RAM and then a load of the output
// register, which waits while the output side stalls.
// ---------------------------------------------------------------------------
module integer_field_formatter (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata, from bit 0: value_bits[63:0], number_base[69:64],
	// min_width[76:70], min_digits[83:77], signed_mode[84], force_plus[85],
	// space_sign[86], zero_pad[87], left_justify[88], alt_prefix[89],
	// upper_case[90], zero fill[95:91]
	input  logic [95:0] s_tdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// m_tdata, from bit 0: char_code[7:0]
	output logic [7:0]  m_tdata,
	// m_tuser, from bit 0: bad_base[0], truncated[1]
	output logic [1:0]  m_tuser,
	output logic        m_tlast,
	output logic        m_tvalid,
	input  logic        m_tready
);

	localparam int VB     = ifmt_pkg::VALUE_BITS;
	localparam int BW     = ifmt_pkg::BASE_W;
	localparam int PW     = ifmt_pkg::POS_W;
	localparam int AW     = ifmt_pkg::DIG_AW;

	// Sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ERR  = 3'd1;
	localparam logic [2:0] ST_CONV = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_LAY1 = 3'd4;
	localparam logic [2:0] ST_LAY2 = 3'd5;
	localparam logic [2:0] ST_RD   = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	// Character kinds picked per position
	localparam logic [2:0] K_SPACE = 3'd0;
	localparam logic [2:0] K_SIGN  = 3'd1;
	localparam logic [2:0] K_PREF0 = 3'd2;
	localparam logic [2:0] K_PREFX = 3'd3;
	localparam logic [2:0] K_ZERO  = 3'd4;
	localparam logic [2:0] K_DIGIT = 3'd5;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LOWA  = 8'h61;
	localparam logic [7:0] CH_UPA   = 8'h41;
	localparam logic [7:0] CH_LOWX  = 8'h78;
	localparam logic [7:0] CH_UPX   = 8'h58;

	localparam logic [PW-1:0] LIMIT_64  = PW'(64);
	localparam logic [PW-1:0] MAX_POS   = PW'(ifmt_pkg::MAX_CHARS);
	localparam logic [BW-1:0] BASE_MIN  = BW'(2);
	localparam logic [BW-1:0] BASE_MAX  = BW'(36);
	localparam logic [BW-1:0] BASE_OCT  = BW'(8);
	localparam logic [BW-1:0] BASE_HEX  = BW'(16);
	localparam logic [BW-1:0] DEC_DIGS  = BW'(10);

	// Map a digit value to its ASCII character.
	function automatic logic [7:0] digit_char(input logic [BW-1:0] d, input logic up);
		logic [7:0] base_ch;
		begin
			base_ch = up ? CH_UPA : CH_LOWA;
			if (d < DEC_DIGS) begin
				digit_char = CH_ZERO + 8'(d);
			end else begin
				digit_char = base_ch + 8'(d - DEC_DIGS);
			end
		end
	endfunction

	// Input field views
	logic [VB-1:0] in_value;
	logic [BW-1:0] in_base;
	logic [6:0]    in_width;
	logic [6:0]    in_prec;
	logic          in_sgn, in_plus, in_spc, in_zero, in_left, in_alt, in_upper;

	assign in_value = s_tdata[VB-1:0];
	assign in_base  = s_tdata[69:64];
	assign in_width = s_tdata[76:70];
	assign in_prec  = s_tdata[83:77];
	assign in_sgn   = s_tdata[84];
	assign in_plus  = s_tdata[85];
	assign in_spc   = s_tdata[86];
	assign in_zero  = s_tdata[87];
	assign in_left  = s_tdata[88];
	assign in_alt   = s_tdata[89];
	assign in_upper = s_tdata[90];

	// Control
	logic [2:0]    state_q;
	logic [PW-1:0] nd_q;
	logic [PW-1:0] pos_q;

	// Per-item parameters
	logic [VB-1:0] mag_q;
	logic [BW-1:0] base_q;
	logic [PW-1:0] width_q, prec_q;
	logic          left_q, zero_q, upper_q, has_sign_q;
	logic [7:0]    sign_ch_q;
	logic [1:0]    pref_len_q;

	// Layout
	logic [PW-1:0] pad_q, total_q;
	logic [PW-1:0] e_lead_q, e_sign_q, e_pref_q, e_prec_q, e_dig_q;
	logic [PW-1:0] last_pos_q;
	logic          trunc_q;
	logic [2:0]    kind_q;
	logic          fin_q;

	// Output register
	logic [7:0]    out_ch_q;
	logic [1:0]    out_user_q;
	logic          out_last_q;
	logic          out_valid_q;

	ifmt_pkg::div_req_t div_req;
	ifmt_pkg::div_rsp_t div_rsp;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [BW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [BW-1:0] ram_rdata;

	logic          accept;
	logic          out_free;
	logic          out_load;
	logic          in_bad;
	logic          in_neg;
	logic [VB-1:0] in_mag;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	// Load the output register with an error result or the next character.
	assign out_load = out_free && (state_q == ST_ERR || state_q == ST_OUT);
	assign in_bad   = (in_base < BASE_MIN) || (in_base > BASE_MAX);
	assign in_neg   = in_sgn && in_value[VB-1];
	assign in_mag   = in_neg ? (~in_value + VB'(1)) : in_value;

	assign s_tready = (state_q == ST_IDLE);

	// Divider drives off the current magnitude.
	assign div_req.start    = (state_q == ST_CONV) && (mag_q != '0);
	assign div_req.dividend = mag_q;
	assign div_req.divisor  = base_q;

	ifmt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Digit writes: a zero value stores a single digit 0.
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = '0;
		ram_waddr = nd_q[AW-1:0];
		if (state_q == ST_CONV && mag_q == '0 && nd_q == '0) begin
			ram_we = 1'b1;
		end else if (state_q == ST_DIV && div_rsp.done) begin
			ram_we    = 1'b1;
			ram_wdata = div_rsp.remainder;
		end
	end

	// Layout stage 1 terms
	logic [PW-1:0] ndp, fixed_len;
	assign ndp       = (nd_q > prec_q) ? nd_q : prec_q;
	assign fixed_len = ndp + PW'(has_sign_q) + PW'(pref_len_q);

	// Layout stage 2 terms
	logic [PW-1:0] lead_len, zpad_len, ndp_now, sign_end, pref_end, prec_end, dig_end;
	assign ndp_now  = (nd_q > prec_q) ? nd_q : prec_q;
	assign lead_len = (zero_q || left_q) ? '0 : pad_q;
	assign zpad_len = zero_q ? pad_q : '0;
	assign sign_end = lead_len + PW'(has_sign_q);
	assign pref_end = sign_end + PW'(pref_len_q);
	assign prec_end = pref_end + zpad_len + (ndp_now - nd_q);
	assign dig_end  = prec_end + nd_q;

	// Character selection for the current position; digits come out most
	// significant first, so the RAM is read top down.
	logic [2:0]    kind_sel;
	logic [PW-1:0] dig_idx;
	always_comb begin
		dig_idx = e_dig_q - PW'(1) - pos_q;
		if (pos_q < e_lead_q) begin
			kind_sel = K_SPACE;
		end else if (pos_q < e_sign_q) begin
			kind_sel = K_SIGN;
		end else if (pos_q < e_pref_q) begin
			kind_sel = (pos_q == e_sign_q) ? K_PREF0 : K_PREFX;
		end else if (pos_q < e_prec_q) begin
			kind_sel = K_ZERO;
		end else if (pos_q < e_dig_q) begin
			kind_sel = K_DIGIT;
		end else begin
			kind_sel = K_SPACE;
		end
	end

	assign ram_re    = (state_q == ST_RD);
	assign ram_raddr = dig_idx[AW-1:0];

	ifmt_ram #(
		.WIDTH (BW),
		.DEPTH (ifmt_pkg::DIG_DEPTH)
	) u_dig_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	logic [7:0] char_sel;
	always_comb begin
		case (kind_q)
			K_SPACE: char_sel = CH_SPACE;
			K_SIGN:  char_sel = sign_ch_q;
			K_PREF0: char_sel = CH_ZERO;
			K_PREFX: char_sel = upper_q ? CH_UPX : CH_LOWX;
			K_ZERO:  char_sel = CH_ZERO;
			K_DIGIT: char_sel = digit_char(ram_rdata, upper_q);
			default: char_sel = CH_SPACE;
		endcase
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nd_q        <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Hold the output until taken; a new load replaces it.
			out_valid_q <= out_load || (out_valid_q && !m_tready);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						nd_q    <= '0;
						pos_q   <= '0;
						state_q <= in_bad ? ST_ERR : ST_CONV;
					end
				end
				ST_ERR: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CONV: begin
					if (mag_q == '0) begin
						if (nd_q == '0) begin
							nd_q <= PW'(1);
						end
						state_q <= ST_LAY1;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						nd_q    <= nd_q + PW'(1);
						state_q <= ST_CONV;
					end
				end
				ST_LAY1: state_q <= ST_LAY2;
				ST_LAY2: state_q <= ST_RD;
				ST_RD:   state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						if (fin_q) begin
							state_q <= ST_IDLE;
						end else begin
							pos_q   <= pos_q + PW'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q      <= in_mag;
			base_q     <= in_base;
			width_q    <= (in_width > LIMIT_64) ? LIMIT_64 : in_width;
			prec_q     <= (in_prec > LIMIT_64) ? LIMIT_64 : in_prec;
			left_q     <= in_left;
			zero_q     <= in_zero && !in_left;
			upper_q    <= in_upper;
			has_sign_q <= in_neg || (in_sgn && (in_plus || in_spc));
			if (in_neg) begin
				sign_ch_q <= CH_MINUS;
			end else if (in_plus) begin
				sign_ch_q <= CH_PLUS;
			end else begin
				sign_ch_q <= CH_SPACE;
			end
			if (in_alt && in_base == BASE_HEX) begin
				pref_len_q <= 2'd2;
			end else if (in_alt && in_base == BASE_OCT) begin
				pref_len_q <= 2'd1;
			end else begin
				pref_len_q <= 2'd0;
			end
		end
		// Advance the magnitude with each quotient.
		if (state_q == ST_DIV && div_rsp.done) begin
			mag_q <= div_rsp.quotient;
		end
		if (state_q == ST_LAY1) begin
			pad_q   <= (width_q > fixed_len) ? (width_q - fixed_len) : '0;
			total_q <= (width_q > fixed_len) ? width_q : fixed_len;
		end
		if (state_q == ST_LAY2) begin
			e_lead_q   <= lead_len;
			e_sign_q   <= sign_end;
			e_pref_q   <= pref_end;
			e_prec_q   <= prec_end;
			e_dig_q    <= dig_end;
			trunc_q    <= total_q > MAX_POS;
			last_pos_q <= ((total_q > MAX_POS) ? MAX_POS : total_q) - PW'(1);
		end
		if (state_q == ST_RD) begin
			kind_q <= kind_sel;
			fin_q  <= (pos_q == last_pos_q);
		end
		if (state_q == ST_ERR && out_free) begin
			out_ch_q   <= 8'h00;
			out_last_q <= 1'b1;
			out_user_q <= 2'b01;
		end else if (state_q == ST_OUT && out_free) begin
			out_ch_q   <= char_sel;
			out_last_q <= fin_q;
			out_user_q <= {fin_q && trunc_q, 1'b0};
		end
	end

	assign m_tdata  = out_ch_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;
	assign m_tvalid = out_valid_q;

`ifndef SYNTHESIS
	// An error result stands alone: last, character 0, never truncated.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast && m_tdata == 8'h00 && !m_tuser[1])
		else $error("bad base result malformed");

	// Truncation is flagged only on the final character.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("truncated flag without last");

	// The divider is idle whenever a new item can be taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_rsp.busy)
		else $error("divider busy while block ready");

	// Digit count never runs past the digit buffer.
	assert property (@(posedge clk) disable iff (!arst_n)
		nd_q <= PW'(ifmt_pkg::DIG_DEPTH))
		else $error("digit count overflow");

	// Emission never runs past the character cap.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_OUT) |-> pos_q < MAX_POS)
		else $error("character position beyond cap");
`endif

endmodule

// ===== tb/sv/field_text_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// field_text_checker: predicts and checks the formatted character stream
// Watches both stream channels of the integer field formatter. Every request
// accepted on the input side is turned into the characters that a printf
// style integer conversion gives, and every character that leaves the block
// is compared with the oldest prediction.
// ---------------------------------------------------------------------------
module field_text_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [95:0] s_tdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        m_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	output int          mismatch_total,
	output int          chars_outstanding
);

	// Width and precision saturate here.
	localparam int unsigned FIELD_LIMIT = 64;
	localparam int          REPORT_MAX  = 10;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
		logic       bad_base;
		logic       truncated;
	} field_char_t;

	field_char_t pending_chars[$];

	// Build the text of one request and queue it character by character.
	function automatic void predict_field(input logic [95:0] word);
		logic [63:0]  vmask;
		logic [63:0]  sbit;
		logic [63:0]  mag;
		int unsigned  base, width, prec, nd, ndp, fixed, pad, total, n, i, d;
		logic         sgn, plus, spc, zero, left, alt, upper;
		byte unsigned sign_ch;
		byte unsigned digits[$];
		byte unsigned text[$];
		field_char_t  c;

		vmask = {64{1'b1}} >> (64 - ifmt_pkg::VALUE_BITS);
		sbit  = 64'd1 << (ifmt_pkg::VALUE_BITS - 1);
		mag   = word[63:0] & vmask;
		base  = 32'(word[69:64]);
		width = 32'(word[76:70]);
		prec  = 32'(word[83:77]);
		sgn   = word[84];
		plus  = word[85];
		spc   = word[86];
		left  = word[88];
		zero  = word[87] && !left;
		alt   = word[89];
		upper = word[90];

		if (base < 2 || base > 36) begin
			c = '{char_code: 8'h00, last: 1'b1, bad_base: 1'b1, truncated: 1'b0};
			pending_chars.push_back(c);
			return;
		end
		if (width > FIELD_LIMIT) width = FIELD_LIMIT;
		if (prec > FIELD_LIMIT) prec = FIELD_LIMIT;

		sign_ch = 8'h00;
		if (sgn) begin
			if ((mag & sbit) != 0) begin
				sign_ch = "-";
				mag = (~mag + 64'd1) & vmask;
			end else if (plus) begin
				sign_ch = "+";
			end else if (spc) begin
				sign_ch = " ";
			end
		end

		// Digits come out least significant first.
		if (mag == 0) begin
			digits.push_back("0");
		end else begin
			while (mag != 0) begin
				d = int'(mag % 64'(base));
				if (d < 10)
					digits.push_back(8'(d) + 8'd48);
				else
					digits.push_back(8'(d - 10) + (upper ? 8'd65 : 8'd97));
				mag = mag / 64'(base);
			end
		end
		nd  = digits.size();
		ndp = (nd > prec) ? nd : prec;

		fixed = ndp + ((sign_ch != 0) ? 1 : 0);
		if (alt && base == 16)
			fixed += 2;
		else if (alt && base == 8)
			fixed += 1;
		pad = (width > fixed) ? width - fixed : 0;

		if (!zero && !left)
			for (i = 0; i < pad; i++) text.push_back(" ");
		if (sign_ch != 0)
			text.push_back(sign_ch);
		if (alt && base == 8) begin
			text.push_back("0");
		end else if (alt && base == 16) begin
			text.push_back("0");
			text.push_back(upper ? "X" : "x");
		end
		if (zero)
			for (i = 0; i < pad; i++) text.push_back("0");
		for (i = nd; i < ndp; i++) text.push_back("0");
		for (i = nd; i > 0; i--) text.push_back(digits[i-1]);
		if (left)
			for (i = 0; i < pad; i++) text.push_back(" ");

		// Cut the field at MAX_CHARS and flag the cut on its final character.
		total = text.size();
		n = (total > ifmt_pkg::MAX_CHARS) ? ifmt_pkg::MAX_CHARS : total;
		for (i = 0; i < n; i++) begin
			c.char_code = text[i];
			c.last      = (i + 1 == n);
			c.bad_base  = 1'b0;
			c.truncated = (i + 1 == n) && (total > ifmt_pkg::MAX_CHARS);
			pending_chars.push_back(c);
		end
	endfunction

	always @(posedge clk) begin
		field_char_t want;
		if (!arst_n) begin
			mismatch_total    <= 0;
			chars_outstanding <= 0;
		end else begin
			// Compare before queuing: a request accepted now cannot answer in this cycle.
			if (m_tvalid && m_tready) begin
				if (pending_chars.size() == 0) begin
					if (mismatch_total < REPORT_MAX)
						$display("%0t: unexpected character %02h (last %0b bad %0b trunc %0b)",
							$time, m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
					mismatch_total <= mismatch_total + 1;
				end else begin
					want = pending_chars.pop_front();
					if (m_tdata !== want.char_code || m_tlast !== want.last ||
					    m_tuser[0] !== want.bad_base || m_tuser[1] !== want.truncated) begin
						if (mismatch_total < REPORT_MAX)
							$display({"%0t: mismatch, expected char %02h last %0b bad %0b ",
								"trunc %0b, got char %02h last %0b bad %0b trunc %0b"},
								$time, want.char_code, want.last, want.bad_base,
								want.truncated, m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
						mismatch_total <= mismatch_total + 1;
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_field(s_tdata);
			chars_outstanding <= pending_chars.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: stimulus and verdict for the integer field formatter
// Sends a directed set of formatting requests that cover the corners of the
// conversion, then a long random mix, with random gaps on the input side and
// random backpressure on the output side. A checker beside the block
// predicts every character and counts the mismatches.
// ---------------------------------------------------------------------------
module tb;

	localparam int WATCHDOG_LIMIT = 8000;
	localparam int DRAIN_CYCLES   = 200;
	localparam int RANDOM_ITEMS   = 285;
	// Random requests in this index range run with no idling on either side.
	localparam int CALM_FIRST     = 140;
	localparam int CALM_LAST      = 199;

	// Format flag masks, in request order from signed_mode up.
	localparam logic [6:0] F_SIGNED = 7'h01;
	localparam logic [6:0] F_PLUS   = 7'h02;
	localparam logic [6:0] F_SPACE  = 7'h04;
	localparam logic [6:0] F_ZERO   = 7'h08;
	localparam logic [6:0] F_LEFT   = 7'h10;
	localparam logic [6:0] F_ALT    = 7'h20;
	localparam logic [6:0] F_UPPER  = 7'h40;
	localparam logic [6:0] F_ALL    = F_SIGNED | F_PLUS | F_SPACE | F_ZERO | F_LEFT |
		F_ALT | F_UPPER;

	localparam logic [63:0] ALL_ONES = {64{1'b1}};
	localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic [95:0] s_tdata  = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        m_tvalid;
	logic        m_tready = 1'b0;

	logic        calm = 1'b0;
	int          mismatch_total;
	int          chars_outstanding;
	int          quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	integer_field_formatter DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	field_text_checker checker_inst (
		.clk               (clk),
		.arst_n            (arst_n),
		.s_tdata           (s_tdata),
		.s_tvalid          (s_tvalid),
		.s_tready          (s_tready),
		.m_tdata           (m_tdata),
		.m_tuser           (m_tuser),
		.m_tlast           (m_tlast),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.mismatch_total    (mismatch_total),
		.chars_outstanding (chars_outstanding)
	);

	// Stall the output side about a quarter of the time, never in the calm stretch.
	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 24);
	end

	// Abort when no transaction moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Pack one request; zero fill sits above upper_case.
	function automatic logic [95:0] pack_request(input logic [63:0] value,
		input logic [5:0] base, input logic [6:0] width, input logic [6:0] prec,
		input logic [6:0] flags);
		return {5'b0, flags, prec, width, base, value};
	endfunction

	// Hold a request until the block takes it; enter and leave at a falling edge.
	task automatic send_request(input logic [95:0] word);
		while (!calm && $urandom_range(99) < 24) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata  <= word;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [63:0] random_value();
		case ($urandom_range(9))
			0, 1, 2: return 64'($urandom_range(1000));
			3, 4, 5: return {$urandom, $urandom};
			6:       return 64'd0 - 64'($urandom_range(1000, 1));
			7: begin
				case ($urandom_range(3))
					0:       return 64'd0;
					1:       return ALL_ONES;
					2:       return MOST_NEG;
					default: return MOST_POS;
				endcase
			end
			8:       return {32'd0, $urandom};
			default: return 64'd1 << $urandom_range(63);
		endcase
	endfunction

	function automatic logic [5:0] random_base();
		int pick;
		pick = $urandom_range(99);
		if (pick < 25) return 6'd10;
		if (pick < 45) return 6'd16;
		if (pick < 55) return 6'd8;
		if (pick < 65) return 6'd2;
		if (pick < 90) return 6'($urandom_range(36, 2));
		// Out-of-range radix: below 2 or above 36.
		if ($urandom_range(1)) return 6'($urandom_range(1));
		return 6'($urandom_range(63, 37));
	endfunction

	function automatic logic [6:0] random_width();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) return 7'($urandom_range(12));
		if (pick < 85) return 7'($urandom_range(64));
		return 7'($urandom_range(127));
	endfunction

	function automatic logic [6:0] random_precision();
		int pick;
		pick = $urandom_range(99);
		if (pick < 60) return 7'd0;
		if (pick < 85) return 7'($urandom_range(8));
		return 7'($urandom_range(127));
	endfunction

	initial begin
		logic [95:0] directed[$];

		// Zero value, unsigned extremes, most negative signed value.
		directed.push_back(pack_request(64'd0, 6'd10, 7'd0, 7'd0, '0));
		directed.push_back(pack_request(ALL_ONES, 6'd10, 7'd0, 7'd0, '0));
		directed.push_back(pack_request(MOST_NEG, 6'd10, 7'd0, 7'd0, F_SIGNED));
		// Prefixes, including on a zero value.
		directed.push_back(pack_request(ALL_ONES, 6'd16, 7'd0, 7'd0, F_SIGNED | F_ALT | F_UPPER));
		directed.push_back(pack_request(64'd255, 6'd16, 7'd10, 7'd0, F_ALT | F_ZERO));
		directed.push_back(pack_request(64'd8, 6'd8, 7'd6, 7'd0, F_ALT));
		directed.push_back(pack_request(64'd0, 6'd8, 7'd0, 7'd0, F_ALT));
		directed.push_back(pack_request(64'd0, 6'd16, 7'd0, 7'd0, F_ALT | F_UPPER));
		// Sign flags, with and without signed mode.
		directed.push_back(pack_request(64'd42, 6'd10, 7'd6, 7'd0, F_SIGNED | F_PLUS));
		directed.push_back(pack_request(64'd42, 6'd10, 7'd6, 7'd0, F_SIGNED | F_SPACE));
		directed.push_back(pack_request(64'd42, 6'd10, 7'd0, 7'd0, F_PLUS | F_SPACE));
		directed.push_back(pack_request(64'd42, 6'd10, 7'd0, 7'd0, F_SIGNED | F_PLUS | F_SPACE));
		// Left justify beats zero pad; zero pad next to precision.
		directed.push_back(pack_request(64'd0 - 64'd7, 6'd10, 7'd12, 7'd0,
			F_SIGNED | F_LEFT | F_ZERO));
		directed.push_back(pack_request(64'd123, 6'd10, 7'd12, 7'd5, F_ZERO));
		directed.push_back(pack_request(64'd0, 6'd10, 7'd0, 7'd5, '0));
		// Bad radix values.
		directed.push_back(pack_request(64'd5, 6'd0, 7'd0, 7'd0, '0));
		directed.push_back(pack_request(ALL_ONES, 6'd1, 7'd127, 7'd127, F_ALL));
		directed.push_back(pack_request(64'd5, 6'd37, 7'd3, 7'd0, F_SIGNED));
		directed.push_back(pack_request(64'd5, 6'd63, 7'd0, 7'd0, '0));
		// Exactly MAX_CHARS characters, twice, then fields cut at MAX_CHARS.
		directed.push_back(pack_request(ALL_ONES, 6'd2, 7'd0, 7'd0, '0));
		directed.push_back(pack_request(MOST_POS, 6'd2, 7'd0, 7'd0, F_SIGNED | F_PLUS));
		directed.push_back(pack_request(ALL_ONES, 6'd16, 7'd0, 7'd64, F_ALT));
		directed.push_back(pack_request(64'd1, 6'd36, 7'd127, 7'd127,
			F_SIGNED | F_SPACE | F_ZERO));
		// Largest radix, both digit cases.
		directed.push_back(pack_request(ALL_ONES, 6'd36, 7'd64, 7'd0, F_UPPER | F_LEFT));
		directed.push_back(pack_request(64'd35, 6'd36, 7'd0, 7'd0, '0));

		// Release reset on a falling edge.
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_request(directed[i]);

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			calm <= (k >= CALM_FIRST && k <= CALM_LAST);
			send_request(pack_request(random_value(), random_base(), random_width(),
				random_precision(), 7'($urandom_range(127))));
		end
		s_tvalid <= 1'b0;
		calm     <= 1'b0;

		// Drain the remaining characters, then watch for strays.
		while (chars_outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_total == 0 && chars_outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== integer_field_formatter.f =====
rtl/core/ifmt_pkg.sv
rtl/core/ifmt_ram.sv
rtl/core/ifmt_div.sv
rtl/core/integer_field_formatter.sv
tb/sv/field_text_checker.sv
tb/sv/tb.sv
